FILE: sv/box_average_filter_defines.svh
// Assertion macros shared by the box average filter modules.
// Each macro expects clk and rst_n in scope; the bodies are empty for synthesis.
`ifndef BOX_AVERAGE_FILTER_DEFINES_SVH
`define BOX_AVERAGE_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// property checked at every edge outside reset
`define BAVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition implies a consequence in the next cycle
`define BAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BAVG_ASSERT(lbl, prop, msg)
`define BAVG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/bavg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the box average filter.
// No dependencies; used by the controller, datapath and top level.
package bavg_pkg;

  // port field widths
  localparam int PIXEL_W      = 16;
  localparam int AVG_W        = 16;
  localparam int CENTER_ROW_W = 12;
  localparam int CENTER_COL_W = 10;

  // running sums wrap at these widths
  localparam int COLSUM_W = 20;
  localparam int WINSUM_W = 24;

  // frame geometry
  localparam int MAX_HEIGHT = 4096;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;

  // configuration port
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int WINDOW_REG_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = CFG_INDEX_W'(2);

  localparam int RST_IMAGE_WIDTH  = 1024;
  localparam int RST_IMAGE_HEIGHT = 1024;
  localparam int RST_WINDOW_SIZE  = 3;

  // controller to datapath
  typedef struct packed {
    logic accept;    // capture pixel, launch memory reads
    logic update;    // write back sums, advance position
    logic multiply;  // form window sum times reciprocal
    logic load;      // move the result into the output register
  } bavg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;      // the last updated pixel completes a window
  } bavg_status_t;

endpackage

FILE: sv/bavg_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// Standalone; instanced for the row store and the column sums.
module bavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/bavg_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the box average filter: handshakes and commands.
// Depends on bavg_pkg and box_average_filter_defines.svh.
`include "box_average_filter_defines.svh"
module bavg_ctrl
  import bavg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  bavg_status_t status,
  output bavg_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_MULT   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_MULT;
      end
      S_MULT: begin
        // drop straight back to idle for border pixels
        cmd.multiply = status.emit;
        state_nxt    = status.emit ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `BAVG_ASSERT(a_load_into_free_slot, cmd.load |-> out_free, "result loaded over a pending one")
  `BAVG_ASSERT_NEXT(a_accept_starts_update, in_valid && in_ready, state_r == S_UPDATE, "no update after transfer")
  `BAVG_ASSERT(a_emit_needs_window, state_r == S_EMIT |-> status.emit, "emit state without a full window")
  `BAVG_ASSERT_NEXT(a_load_shows_result, cmd.load, out_valid_r, "loaded result not presented")

endmodule

FILE: sv/bavg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the box average filter: configuration, positions, line stores, sums, mean.
// Depends on bavg_pkg, bavg_ram and box_average_filter_defines.svh.
`include "box_average_filter_defines.svh"
module bavg_datapath
  import bavg_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [PIXEL_W-1:0]      in_pixel,
  input  bavg_cmd_t               cmd,
  output bavg_status_t            status,
  output logic [AVG_W-1:0]        out_average,
  output logic [CENTER_ROW_W-1:0] out_center_row,
  output logic [CENTER_COL_W-1:0] out_center_col,
  output logic                    out_frame_last
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
  localparam int MOD_W    = $clog2(MAX_WINDOW);
  localparam int RS_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int RS_AW    = $clog2(RS_DEPTH);
  // reciprocal scale: exact truncated quotient for any 24-bit sum and N*N divisor
  localparam int K        = WINSUM_W + $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int M_W      = K - 1;
  localparam int PROD_W   = WINSUM_W + M_W;
  localparam int W_RST    = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;

  // configuration
  logic [WID_W-1:0]        w_r, w_nxt;
  logic [HEIGHT_W-1:0]     h_r, h_nxt;
  logic [WIN_W-1:0]        n_r, n_nxt;
  logic                    cfg_restart;
  logic [WIDTH_REG_W-1:0]  wv;
  logic [HEIGHT_REG_W-1:0] hv;
  logic [WINDOW_REG_W-1:0] nv;

  // position and running state
  logic [ROW_W-1:0]    r_r, r_nxt;
  logic [COL_W-1:0]    c_r, c_nxt;
  logic [MOD_W-1:0]    row_mod_r, row_mod_nxt;
  logic [RS_AW-1:0]    row_base_r, row_base_nxt;
  logic [WINSUM_W-1:0] ws_r, ws_nxt;
  logic                emit_r;

  // per-pixel work
  logic [PIXEL_BITS-1:0] pix_r;
  logic [PIXEL_BITS-1:0] rs_rdata, old_pix;
  logic [COLSUM_W-1:0]   cs_rdata, cs_prev, cs_new, cs_tap;
  logic [COLSUM_W-1:0]   cs_line_r [MAX_WINDOW];
  logic [WINSUM_W-1:0]   ws_base, ws_sub, ws_upd;
  logic                  row_full, col_full, row_end, frame_end;
  logic [RS_AW-1:0]      rs_addr;
  logic                  mem_en;

  logic [CENTER_ROW_W-1:0] crow_r;
  logic [CENTER_COL_W-1:0] ccol_r;
  logic                    last_r;

  logic [M_W-1:0]    recip_tab [MAX_WINDOW + 1];
  logic [M_W-1:0]    recip_r;
  logic [PROD_W-1:0] prod_r;
  logic [AVG_W-1:0]  avg;

  logic [AVG_W-1:0]        average_r;
  logic [CENTER_ROW_W-1:0] center_row_r;
  logic [CENTER_COL_W-1:0] center_col_r;
  logic                    frame_last_r;

  // reciprocal table, one entry per window side; side 1 bypasses the multiplier
  assign recip_tab[0] = '0;
  assign recip_tab[1] = '0;
  for (genvar g = 2; g <= MAX_WINDOW; g++) begin : g_recip
    localparam longint unsigned DIV   = longint'(g) * longint'(g);
    localparam longint unsigned RECIP = ((64'd1 << K) + DIV - 64'd1) / DIV;
    assign recip_tab[g] = M_W'(RECIP);
  end

  // configuration writes, clamped to the supported ranges
  always_comb begin
    wv          = cfg_data[WIDTH_REG_W-1:0];
    hv          = cfg_data[HEIGHT_REG_W-1:0];
    nv          = cfg_data[WINDOW_REG_W-1:0];
    w_nxt       = w_r;
    h_nxt       = h_r;
    n_nxt       = n_r;
    cfg_restart = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          cfg_restart = 1'b1;
          if (wv == '0) begin
            w_nxt = WID_W'(1);
          end else if (32'(wv) > MAX_WIDTH) begin
            w_nxt = WID_W'(MAX_WIDTH);
          end else begin
            w_nxt = WID_W'(wv);
          end
        end
        REG_IMAGE_HEIGHT: begin
          cfg_restart = 1'b1;
          if (hv == '0) begin
            h_nxt = HEIGHT_W'(1);
          end else if (32'(hv) > MAX_HEIGHT) begin
            h_nxt = HEIGHT_W'(MAX_HEIGHT);
          end else begin
            h_nxt = HEIGHT_W'(hv);
          end
        end
        REG_WINDOW_SIZE: begin
          cfg_restart = 1'b1;
          if (nv == '0) begin
            n_nxt = WIN_W'(1);
          end else if (32'(nv) > MAX_WINDOW) begin
            n_nxt = WIN_W'(MAX_WINDOW);
          end else begin
            n_nxt = WIN_W'(nv);
          end
        end
        default: ;
      endcase
    end
  end

  // column and window sum update
  always_comb begin
    // first N rows of a frame have nothing to retire; row 0 starts from cleared sums
    old_pix   = (32'(r_r) >= 32'(n_r)) ? rs_rdata : '0;
    cs_prev   = (r_r == '0) ? '0 : cs_rdata;
    cs_new    = cs_prev + COLSUM_W'(pix_r) - COLSUM_W'(old_pix);
    cs_tap    = cs_line_r[MOD_W'(n_r - 1'b1)];
    ws_base   = (c_r == '0) ? '0 : ws_r;
    ws_sub    = (32'(c_r) >= 32'(n_r)) ? WINSUM_W'(cs_tap) : '0;
    ws_upd    = ws_base + WINSUM_W'(cs_new) - ws_sub;
    row_full  = (32'(r_r) + 1 >= 32'(n_r));
    col_full  = (32'(c_r) + 1 >= 32'(n_r));
    row_end   = (32'(c_r) + 1 >= 32'(w_r));
    frame_end = (32'(r_r) + 1 >= 32'(h_r));
  end

  // raster position and line slot
  always_comb begin
    r_nxt        = r_r;
    c_nxt        = c_r;
    row_mod_nxt  = row_mod_r;
    row_base_nxt = row_base_r;
    ws_nxt       = ws_r;
    if (cfg_restart) begin
      r_nxt        = '0;
      c_nxt        = '0;
      row_mod_nxt  = '0;
      row_base_nxt = '0;
      ws_nxt       = '0;
    end else if (cmd.update) begin
      ws_nxt = ws_upd;
      if (row_end) begin
        c_nxt = '0;
        if (frame_end) begin
          r_nxt        = '0;
          row_mod_nxt  = '0;
          row_base_nxt = '0;
        end else begin
          r_nxt = r_r + 1'b1;
          if (32'(row_mod_r) + 1 >= 32'(n_r)) begin
            row_mod_nxt  = '0;
            row_base_nxt = '0;
          end else begin
            row_mod_nxt  = row_mod_r + 1'b1;
            row_base_nxt = row_base_r + RS_AW'(MAX_WIDTH);
          end
        end
      end else begin
        c_nxt = c_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r        <= WID_W'(W_RST);
      h_r        <= HEIGHT_W'(RST_IMAGE_HEIGHT);
      n_r        <= WIN_W'(RST_WINDOW_SIZE);
      r_r        <= '0;
      c_r        <= '0;
      row_mod_r  <= '0;
      row_base_r <= '0;
      ws_r       <= '0;
      emit_r     <= 1'b0;
    end else begin
      w_r        <= w_nxt;
      h_r        <= h_nxt;
      n_r        <= n_nxt;
      r_r        <= r_nxt;
      c_r        <= c_nxt;
      row_mod_r  <= row_mod_nxt;
      row_base_r <= row_base_nxt;
      ws_r       <= ws_nxt;
      if (cmd.update) begin
        emit_r <= row_full && col_full;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    recip_r <= recip_tab[n_r];
    if (cmd.accept) begin
      pix_r <= in_pixel[PIXEL_BITS-1:0];
    end
    if (cmd.update) begin
      cs_line_r[0] <= cs_new;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        cs_line_r[i] <= cs_line_r[i-1];
      end
      crow_r <= CENTER_ROW_W'(32'(r_r) + 1 - 32'(n_r) + 32'(n_r >> 1));
      ccol_r <= CENTER_COL_W'(32'(c_r) + 1 - 32'(n_r) + 32'(n_r >> 1));
      last_r <= row_end && frame_end;
    end
    if (cmd.multiply) begin
      prod_r <= PROD_W'(ws_r) * PROD_W'(recip_r);
    end
    if (cmd.load) begin
      average_r    <= avg;
      center_row_r <= crow_r;
      center_col_r <= ccol_r;
      frame_last_r <= last_r;
    end
  end

  assign avg = (n_r == WIN_W'(1)) ? AVG_W'(ws_r) : prod_r[K +: AVG_W];

  assign rs_addr = row_base_r + RS_AW'(c_r);
  assign mem_en  = cmd.accept || cmd.update;

  bavg_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (RS_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (cmd.update),
    .addr  (rs_addr),
    .wdata (pix_r),
    .rdata (rs_rdata)
  );

  bavg_ram #(
    .WIDTH (COLSUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_column_sums (
    .clk   (clk),
    .en    (mem_en),
    .we    (cmd.update),
    .addr  (c_r),
    .wdata (cs_new),
    .rdata (cs_rdata)
  );

  assign status.emit    = emit_r;
  assign out_average    = average_r;
  assign out_center_row = center_row_r;
  assign out_center_col = center_col_r;
  assign out_frame_last = frame_last_r;

  `BAVG_ASSERT(a_col_inside_row, 32'(c_r) < 32'(w_r), "column position beyond image width")
  `BAVG_ASSERT(a_row_inside_frame, 32'(r_r) < 32'(h_r), "row position beyond image height")
  `BAVG_ASSERT(a_slot_in_window, 32'(row_mod_r) < 32'(n_r), "line slot beyond window size")
  `BAVG_ASSERT(a_slot_base, 32'(row_base_r) == 32'(row_mod_r) * MAX_WIDTH, "line base out of step")

endmodule

FILE: sv/box_average_filter.sv
`timescale 1ns / 1ps
// Box average filter: N by N mean over a raster-order grayscale pixel stream.
// Pixels enter on in_valid/in_ready, one per transfer, rows top to bottom.
// Each window that fits inside the image gives one result when its bottom-right
// pixel arrives: truncated mean, window centre row and column, and a frame_last
// flag on the frame's final result. Border pixels give no result.
// A pixel is taken only in the idle state, once the previous pixel is through:
// the transfer reads the row store and column sum memories, the update writes
// them back and updates the window sum, and for a pixel that completes a window
// the sum is multiplied by the reciprocal of N*N and the mean is loaded into the
// output register, which raises out_valid. The output register holds a result
// until out_ready; the next pixel is still taken meanwhile, but a following result
// waits for it in the emit state and no pixel is taken until that result loads.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once,
// clamp to the supported range and restart the frame; unknown indexes are ignored.
// Reset restores width 1024, height 1024 and window 3 and starts a new frame.
// No clearing pass is needed: line data is only read once written in the frame.
module box_average_filter
  import bavg_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIXEL_W-1:0]      in_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [AVG_W-1:0]        out_average,
  output logic [CENTER_ROW_W-1:0] out_center_row,
  output logic [CENTER_COL_W-1:0] out_center_col,
  output logic                    out_frame_last
);

  bavg_cmd_t    cmd;
  bavg_status_t status;

  bavg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bavg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pixel       (in_pixel),
    .cmd            (cmd),
    .status         (status),
    .out_average    (out_average),
    .out_center_row (out_center_row),
    .out_center_col (out_center_col),
    .out_frame_last (out_frame_last)
  );

endmodule

FILE: dv/box_average_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_average_filter: streams pixel frames under many
// geometries and window sizes and checks each window mean against a local model.
// Depends on bavg_pkg and the box_average_filter top level only.
module box_average_filter_tb;
  import bavg_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_WIN       = 15;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PIXELS = 700;
  localparam int TALL_PIXELS   = 48;
  localparam int REPORT_LIMIT  = 10;
  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [AVG_W-1:0]        average;
    logic [CENTER_ROW_W-1:0] center_row;
    logic [CENTER_COL_W-1:0] center_col;
    logic                    frame_last;
  } window_mean_t;

  class box_mean_tracker;
    logic [WIDTH_REG_W-1:0]  img_w;
    logic [HEIGHT_REG_W-1:0] img_h;
    logic [WINDOW_REG_W-1:0] win_n;
    bit [PIXEL_W-1:0]        line_mem [MAX_WIN*MAX_W];
    int unsigned             col_sum [MAX_W];
    int unsigned             win_sum;
    int unsigned             row_pos;
    int unsigned             col_pos;
    window_mean_t            pending_means [$];
    int                      faults;

    function new();
      img_w  = WIDTH_REG_W'(RST_IMAGE_WIDTH);
      img_h  = HEIGHT_REG_W'(RST_IMAGE_HEIGHT);
      win_n  = WINDOW_REG_W'(RST_WINDOW_SIZE);
      faults = 0;
      restart();
    endfunction

    function void restart();
      foreach (col_sum[i]) col_sum[i] = 0;
      win_sum = 0;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int unsigned clamp_reg(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int unsigned frame_pixels();
      return clamp_reg(img_w, MAX_W) * clamp_reg(img_h, MAX_HEIGHT);
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: begin
          img_w = data[WIDTH_REG_W-1:0];
          restart();
        end
        REG_IMAGE_HEIGHT: begin
          img_h = data[HEIGHT_REG_W-1:0];
          restart();
        end
        REG_WINDOW_SIZE: begin
          win_n = data[WINDOW_REG_W-1:0];
          restart();
        end
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] pix);
      int unsigned  w, h, n, r, c, slot, old;
      window_mean_t m;
      w = clamp_reg(img_w, MAX_W);
      h = clamp_reg(img_h, MAX_HEIGHT);
      n = clamp_reg(win_n, MAX_WIN);
      r = (row_pos >= h) ? h - 1 : row_pos;
      c = (col_pos >= w) ? w - 1 : col_pos;
      // line slot is reused every n rows; the old value leaves the column sum
      slot = (r % n) * MAX_W + c;
      old  = (r >= n) ? line_mem[slot] : 0;
      line_mem[slot] = pix;
      col_sum[c] = (col_sum[c] + pix - old) & 32'h000F_FFFF;
      if (c == 0) win_sum = 0;
      win_sum += col_sum[c];
      if (c >= n) win_sum -= col_sum[c - n];
      win_sum &= 32'h00FF_FFFF;
      if (r + 1 >= n && c + 1 >= n) begin
        m.average    = AVG_W'(win_sum / (n * n));
        m.center_row = CENTER_ROW_W'(r + 1 - n + n / 2);
        m.center_col = CENTER_COL_W'(c + 1 - n + n / 2);
        m.frame_last = (r + 1 == h) && (c + 1 == w);
        pending_means.push_back(m);
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        if (r + 1 >= h) restart();
        else row_pos = r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void check_mean(window_mean_t got);
      window_mean_t want;
      if (pending_means.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("unexpected mean: avg %0d row %0d col %0d last %0b",
                   got.average, got.center_row, got.center_col, got.frame_last);
        return;
      end
      want = pending_means.pop_front();
      if (got.average !== want.average || got.center_row !== want.center_row ||
          got.center_col !== want.center_col || got.frame_last !== want.frame_last) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("mean mismatch (avg/row/col/last): expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                   want.average, want.center_row, want.center_col, want.frame_last,
                   got.average, got.center_row, got.center_col, got.frame_last);
      end
    endfunction

    function void report_leftovers();
      if (pending_means.size() != 0) begin
        faults += pending_means.size();
        $display("%0d expected means never arrived", pending_means.size());
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PIXEL_W-1:0]      in_pixel = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [AVG_W-1:0]        out_average;
  logic [CENTER_ROW_W-1:0] out_center_row;
  logic [CENTER_COL_W-1:0] out_center_col;
  logic                    out_frame_last;

  int unsigned     send_idle_pct = 11;
  int unsigned     recv_idle_pct = 60;
  box_mean_tracker tracker;

  box_average_filter uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_center_row (out_center_row),
    .out_center_col (out_center_col),
    .out_frame_last (out_frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check each transfer, then pick the next ready
  always @(posedge clk) begin : result_side
    window_mean_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.average    = out_average;
      seen.center_row = out_center_row;
      seen.center_col = out_center_col;
      seen.frame_last = out_frame_last;
      tracker.check_mean(seen);
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // end the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [PIXEL_W-1:0] pick_pixel(bit saturate);
    int unsigned p;
    if (saturate) return '1;
    p = $urandom_range(9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return PIXEL_W'($urandom);
  endfunction

  // valid stays high across back-to-back transfers; drop it only for a gap
  task automatic send_pixel(logic [PIXEL_W-1:0] pix);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (!in_ready);
    tracker.note_pixel(pix);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper data bits carry noise; the block must drop them
  task automatic configure(int unsigned w, int unsigned h, int unsigned n);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(($urandom << WIDTH_REG_W) | w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(($urandom << WINDOW_REG_W) | n));
    end_writes();
  endtask

  // wait for the last mean, then idle while the pipeline drains
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned w, h, n, lim, pick, count, random_sent, phase_end;
    bit          saturate;
    tracker = new();
    random_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: partial first row, then a write restarts the frame
    repeat (4) send_pixel(PIXEL_W'($urandom));
    settle();
    // full-scale pixels in a window that just fits
    configure(3, 3, 3);
    repeat (9) send_pixel('1);
    settle();
    // zero registers act as one
    configure(0, 0, 0);
    send_pixel('0);
    settle();
    // a spare-index write mid-frame must not restart it
    configure(4, 2, 2);
    send_pixel(16'h0001);
    send_pixel(16'h8000);
    send_pixel(16'h5555);
    settle();
    write_reg(REG_SPARE, '1);
    end_writes();
    send_pixel(16'hAAAA);
    send_pixel('1);
    send_pixel('0);
    send_pixel(16'h7FFF);
    send_pixel(16'hFFFE);
    settle();
    // window larger than the image: no results
    configure(2, 2, 5);
    repeat (4) send_pixel(PIXEL_W'($urandom));
    settle();

    while (random_sent < RANDOM_PIXELS) begin
      if (random_sent >= 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase_end     = RANDOM_PIXELS;
      end else if (random_sent >= RANDOM_PIXELS / 3) begin
        send_idle_pct = 60;
        recv_idle_pct = 11;
        phase_end     = 2 * RANDOM_PIXELS / 3;
      end else begin
        phase_end = RANDOM_PIXELS / 3;
      end
      pick = $urandom_range(99);
      if (pick < 70) w = $urandom_range(1, 12);
      else if (pick < 95) w = $urandom_range(13, 40);
      else w = $urandom_range(41, MAX_W);
      h = (w > 40) ? $urandom_range(1, 3) : $urandom_range(1, 12);
      lim = (w < h) ? w : h;
      if (lim > MAX_WIN) lim = MAX_WIN;
      pick = $urandom_range(99);
      if (pick < 80) n = $urandom_range(1, lim);
      else if (pick < 90) n = 0;
      else n = $urandom_range(1, MAX_WIN);
      configure(w, h, n);
      saturate = ($urandom_range(99) < 15);
      // mostly whole frames; now and then a frame cut short by the next write
      if ($urandom_range(99) < 15 && tracker.frame_pixels() > 1)
        count = $urandom_range(1, tracker.frame_pixels() - 1);
      else
        count = tracker.frame_pixels() * $urandom_range(1, 2);
      // keep each idling phase within its share of the pixels
      if (count > phase_end - random_sent) count = phase_end - random_sent;
      repeat (count) send_pixel(pick_pixel(saturate));
      random_sent += count;
      settle();
    end

    // width above the maximum clamps; the widest row reaches the last centre column
    configure($urandom_range(MAX_W + 1, 2047), 1, 1);
    repeat (tracker.frame_pixels()) send_pixel(pick_pixel(1'b0));
    settle();
    // height at or above the maximum ends at the maximum; send only the head of such a frame
    configure(1, $urandom_range(MAX_HEIGHT, 8191), 1);
    repeat (TALL_PIXELS) send_pixel(pick_pixel(1'b0));
    settle();

    tracker.report_leftovers();
    if (tracker.faults == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/bavg_pkg.sv
sv/bavg_ram.sv
sv/bavg_ctrl.sv
sv/bavg_datapath.sv
sv/box_average_filter.sv
dv/box_average_filter_tb.sv
